### hdl/rc5_pkg.sv
// shared types, constants and rotate helpers for the rc5 cipher block
`default_nettype none
package rc5_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORDS_0_1  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORDS_2_3  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORDS_4_5  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORDS_6_7  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_COUNT = 3'd4;

  localparam logic [3:0] KEY_COUNT_RESET = 4'd4;

  // operation codes
  localparam logic [1:0] OP_ENCRYPT = 2'd0;
  localparam logic [1:0] OP_DECRYPT = 2'd1;
  localparam logic [1:0] OP_EXPAND  = 2'd2;

  localparam logic [31:0] RC5_P = 32'hb7e15163;
  localparam logic [31:0] RC5_Q = 32'h9e3779b9;

  typedef enum logic [2:0] {
    MODE_ENC_WHITEN = 3'd0,
    MODE_ENC_ROUND  = 3'd1,
    MODE_DEC_ROUND  = 3'd2,
    MODE_DEC_WHITEN = 3'd3,
    MODE_MIX        = 3'd4
  } rc5_mode_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] block_a;
    logic [31:0] block_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
  } out_item_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage
`default_nettype wire

### hdl/rc5_round.sv
// shared rc5 datapath: one cipher round, whitening, or one key-mixing step
`default_nettype none
module rc5_round (
  input  wire rc5_pkg::rc5_mode_t mode,
  input  wire logic [31:0]        a,
  input  wire logic [31:0]        b,
  input  wire logic [31:0]        k0,
  input  wire logic [31:0]        k1,
  output logic [31:0]             a_out,
  output logic [31:0]             b_out
);
  import rc5_pkg::*;

  logic [31:0] enc_a;
  logic [31:0] dec_b;
  logic [31:0] mix_a;
  logic [31:0] mix_s;

  always_comb begin
    enc_a = rotl32(a ^ b, b[4:0]) + k0;
    dec_b = rotr32(b - k1, a[4:0]) ^ a;
    mix_a = rotl32(k0 + a + b, 5'd3);
    mix_s = mix_a + b;
    unique case (mode)
      MODE_ENC_WHITEN: begin
        a_out = a + k0;
        b_out = b + k1;
      end
      MODE_ENC_ROUND: begin
        a_out = enc_a;
        b_out = rotl32(b ^ enc_a, enc_a[4:0]) + k1;
      end
      MODE_DEC_ROUND: begin
        a_out = rotr32(a - k0, dec_b[4:0]) ^ dec_b;
        b_out = dec_b;
      end
      MODE_DEC_WHITEN: begin
        a_out = a - k0;
        b_out = b - k1;
      end
      MODE_MIX: begin
        // k1 carries the key word, result goes back to the key word store
        a_out = mix_a;
        b_out = rotl32(k1 + mix_s, mix_s[4:0]);
      end
      default: begin
        a_out = a;
        b_out = b;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/rc5_block_cipher.sv
// rc5-32 block cipher top level: sequencer, round-key ram and key store
//
// Input words carry an operation (encrypt, decrypt, expand key) and a 64-bit
// block as two 32-bit halves; every accepted word yields exactly one output
// word. Both channels use valid/ready. Key registers are written through the
// cfg port; the user must do so only while idle (the block does not check).
// Encrypt/decrypt: one shared round unit does a whole round per cycle, reading
// two round keys per cycle from the dual-read round-key ram. The word passes
// through the prime, cipher and finish states; the result becomes valid and
// in_ready returns on the same edge, so a new block waits for the last one.
// Expand key: the seed state fills the table, then one mixing step per cycle
// for 3*max(TABLE_WORDS, key words) steps, bound by the single read/write
// port pair of the ram; the result (zero) then passes the finish state.
// The unused operation code goes straight to the finish state and returns zero.
// in_ready is high only while idle. A finished result waits in the sequencer
// until the output register is free, so a stalled receiver stalls the block.
// Reset clears control state, zeroes the key registers and sets the key word
// count to 4. The round-key table is not cleared: expand a key before use.
`default_nettype none
module rc5_block_cipher #(
  parameter int ROUNDS        = 16,
  parameter int TABLE_WORDS   = 34,
  parameter int MAX_KEY_WORDS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rc5_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rc5_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_write,
  input  wire logic [rc5_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rc5_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rc5_pkg::*;

  localparam int AW        = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int PW        = $clog2(ROUNDS + 2);
  localparam int JW        = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int LO_WORDS  = (MAX_KEY_WORDS < 4) ? MAX_KEY_WORDS : 4;
  localparam int MAX_STEPS = 3 * ((TABLE_WORDS > MAX_KEY_WORDS) ? TABLE_WORDS : MAX_KEY_WORDS);
  localparam int SW        = $clog2(MAX_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PRIME = 6'b000010,
    ST_CIPH  = 6'b000100,
    ST_SEED  = 6'b001000,
    ST_MIX   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;

  logic [63:0]   key_regs [4];
  logic [3:0]    key_count;
  logic [31:0]   mix_words [MAX_KEY_WORDS];
  logic [31:0]   round_keys [TABLE_WORDS];

  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   seed;
  logic          dec;
  logic [PW-1:0] pc;
  logic [AW-1:0] i;
  logic [JW-1:0] j;
  logic [JW-1:0] j_last;
  logic [SW-1:0] st;

  logic [31:0]   rk0;
  logic [31:0]   rk1;
  logic          z0;
  logic          z1;

  logic          in_fire;
  logic          load_keys;
  logic [PW-1:0] pc_step;
  logic          ciph_last;
  logic [PW-1:0] pair;
  logic [7:0]    idx0;
  logic [7:0]    idx1;
  logic          ok0;
  logic          ok1;
  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;
  logic          zero0;
  logic [AW-1:0] i_next;
  logic [JW-1:0] j_next;
  logic          mem_we;
  logic [31:0]   mem_wdata;
  logic [3:0]    words;
  logic [7:0]    max_w;
  logic [9:0]    steps;

  rc5_mode_t     mode;
  logic [31:0]   k0;
  logic [31:0]   k1;
  logic [31:0]   ua;
  logic [31:0]   ub;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_keys = in_fire && (in_data.operation == OP_EXPAND);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 4; n++) begin
        key_regs[n] <= '0;
      end
      key_count <= KEY_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_WORDS_0_1:  key_regs[0] <= cfg_data;
        CFG_KEY_WORDS_2_3:  key_regs[1] <= cfg_data;
        CFG_KEY_WORDS_4_5:  key_regs[2] <= cfg_data;
        CFG_KEY_WORDS_6_7:  key_regs[3] <= cfg_data;
        CFG_KEY_WORD_COUNT: key_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // key word count saturated into the supported range, and the mix step count
  always_comb begin
    if (key_count < 4'(LO_WORDS)) begin
      words = 4'(LO_WORDS);
    end else if (key_count > 4'(MAX_KEY_WORDS)) begin
      words = 4'(MAX_KEY_WORDS);
    end else begin
      words = key_count;
    end
    max_w = (8'(words) > 8'(TABLE_WORDS)) ? 8'(words) : 8'(TABLE_WORDS);
    steps = 10'(max_w) * 10'd3;
  end

  // cipher key-pair sequencing
  assign pc_step   = dec ? pc - PW'(1) : pc + PW'(1);
  assign ciph_last = dec ? (pc == '0) : (pc == PW'(ROUNDS));

  assign i_next = (i == AW'(TABLE_WORDS - 1)) ? '0 : i + AW'(1);
  assign j_next = (j == j_last) ? '0 : j + JW'(1);

  // round-key ram addressing; keys past the table read as zero
  always_comb begin
    pair = (state == ST_PRIME) ? pc : pc_step;
    idx0 = 8'({pair, 1'b0});
    idx1 = 8'({pair, 1'b1});
    ok0  = idx0 < 8'(TABLE_WORDS);
    ok1  = idx1 < 8'(TABLE_WORDS);
    if (state == ST_PRIME || state == ST_CIPH) begin
      raddr0 = ok0 ? idx0[AW-1:0] : '0;
      zero0  = !ok0;
    end else begin
      // prefetch the next mixing entry; entry 0 while seeding
      raddr0 = (state == ST_MIX) ? i_next : '0;
      zero0  = 1'b0;
    end
    raddr1 = ok1 ? idx1[AW-1:0] : '0;
  end

  assign mem_we    = (state == ST_SEED) || (state == ST_MIX);
  assign mem_wdata = (state == ST_SEED) ? seed : ua;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      round_keys[i] <= mem_wdata;
    end
    rk0 <= round_keys[raddr0];
    rk1 <= round_keys[raddr1];
    z0  <= zero0;
    z1  <= !ok1;
  end

  // key mixing words: loaded from config at expand, updated each mix step
  for (genvar g = 0; g < MAX_KEY_WORDS; g++) begin : g_mix
    localparam int KR = g / 2;
    always_ff @(posedge clk) begin
      if (load_keys) begin
        mix_words[g] <= (g % 2 == 1) ? key_regs[KR][63:32] : key_regs[KR][31:0];
      end else if (state == ST_MIX && j == JW'(g)) begin
        mix_words[g] <= ub;
      end
    end
  end

  // shared arithmetic unit
  always_comb begin
    if (state == ST_CIPH) begin
      if (dec) begin
        mode = (pc == '0) ? MODE_DEC_WHITEN : MODE_DEC_ROUND;
      end else begin
        mode = (pc == '0) ? MODE_ENC_WHITEN : MODE_ENC_ROUND;
      end
    end else begin
      mode = MODE_MIX;
    end
    k0 = z0 ? '0 : rk0;
    k1 = (state == ST_MIX) ? mix_words[j] : (z1 ? '0 : rk1);
  end

  rc5_round u_round (
    .mode  (mode),
    .a     (a),
    .b     (b),
    .k0    (k0),
    .k1    (k1),
    .a_out (ua),
    .b_out (ub)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            a   <= in_data.block_a;
            b   <= in_data.block_b;
            dec <= (in_data.operation == OP_DECRYPT);
            case (in_data.operation)
              OP_ENCRYPT: begin
                pc    <= '0;
                state <= ST_PRIME;
              end
              OP_DECRYPT: begin
                pc    <= PW'(ROUNDS);
                state <= ST_PRIME;
              end
              OP_EXPAND: begin
                i      <= '0;
                seed   <= RC5_P;
                j_last <= JW'(words - 4'd1);
                st     <= SW'(steps - 10'd1);
                state  <= ST_SEED;
              end
              default: begin
                a     <= '0;
                b     <= '0;
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_PRIME: begin
          state <= ST_CIPH;
        end
        ST_CIPH: begin
          a  <= ua;
          b  <= ub;
          pc <= pc_step;
          if (ciph_last) begin
            state <= ST_FIN;
          end
        end
        ST_SEED: begin
          seed <= seed + RC5_Q;
          i    <= i + AW'(1);
          if (i == AW'(TABLE_WORDS - 1)) begin
            i     <= '0;
            j     <= '0;
            a     <= '0;
            b     <= '0;
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          a  <= ua;
          b  <= ub;
          i  <= i_next;
          j  <= j_next;
          st <= st - SW'(1);
          if (st == '0) begin
            a     <= '0;
            b     <= '0;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            out_data.out_a <= a;
            out_data.out_b <= b;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result word appears only when the sequencer hands one over
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("output word raised outside the finish state");

  // the round-key table is written only during key expansion
  a_ram_write_expand: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SEED || state == ST_MIX))
    else $error("round-key write outside key expansion");

  // cipher pair counter stays within the round schedule
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CIPH) |-> (pc <= PW'(ROUNDS)))
    else $error("round counter out of range");

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != ST_IDLE))
    else $error("accepted word left the block idle");
`endif

endmodule
`default_nettype wire

### dv/tb.sv
// testbench for rc5_block_cipher: directed vectors, keyed random phases, rc5 predictor
`timescale 1ns / 100ps
module tb;
  import rc5_pkg::*;

  localparam int ROUND_COUNT = 16;
  localparam int KEY_TABLE   = 34;
  localparam int KEY_SLOTS   = 8;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 75;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          fixed_result;
    logic [31:0] ea;
    logic [31:0] eb;
  } opening_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_KEY_WORDS_0_1;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // mirror of the key registers and the round-key schedule
  bit [63:0] key_reg_copy [4] = '{default: 64'h0};
  bit [3:0]  word_count_copy = KEY_COUNT_RESET;
  bit [31:0] sched [KEY_TABLE];

  out_item_t blocks_due [$];
  out_item_t due_block;
  bit [63:0] last_cipher = '0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        send_gaps = 1'b1;
  bit        recv_stalls = 1'b1;
  bit        hold_off_req = 1'b0;

  opening_row_t opening_vectors [14] = '{
    '{OP_EXPAND,  32'h00000000, 32'h00000000, 1'b1, 32'h0, 32'h0},
    '{OP_UNUSED,  32'hffffffff, 32'hffffffff, 1'b1, 32'h0, 32'h0},
    '{OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
    '{OP_ENCRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
    '{OP_DECRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
    '{OP_DECRYPT, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
    '{OP_ENCRYPT, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
    '{OP_DECRYPT, 32'h00000001, 32'h80000000, 1'b0, 32'h0, 32'h0},
    '{OP_ENCRYPT, 32'h0000001f, 32'h00000020, 1'b0, 32'h0, 32'h0},
    '{OP_DECRYPT, 32'h5555aaaa, 32'haaaa5555, 1'b0, 32'h0, 32'h0},
    '{OP_UNUSED,  32'h00000000, 32'h00000000, 1'b1, 32'h0, 32'h0},
    // block halves are ignored on a key expansion
    '{OP_EXPAND,  32'hffffffff, 32'h12345678, 1'b1, 32'h0, 32'h0},
    '{OP_ENCRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0, 32'h0, 32'h0},
    '{OP_DECRYPT, 32'h7fffffff, 32'hfffffffe, 1'b0, 32'h0, 32'h0}
  };

  rc5_block_cipher #(
    .ROUNDS(ROUND_COUNT),
    .TABLE_WORDS(KEY_TABLE),
    .MAX_KEY_WORDS(KEY_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [31:0] spin_left(bit [31:0] x, bit [4:0] n);
    return (n == 5'd0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic bit [31:0] spin_right(bit [31:0] x, bit [4:0] n);
    return (n == 5'd0) ? x : ((x >> n) | (x << (32 - n)));
  endfunction

  task automatic expand_schedule();
    bit [31:0] mix [KEY_SLOTS];
    bit [31:0] a;
    bit [31:0] b;
    bit [31:0] amt;
    int        words;
    int        steps;
    int        i;
    int        j;
    words = word_count_copy;
    // count saturates into 4..8
    if (words < 4) words = 4;
    if (words > KEY_SLOTS) words = KEY_SLOTS;
    for (int n = 0; n < words; n++) mix[n] = key_reg_copy[n / 2][32 * (n % 2) +: 32];
    sched[0] = RC5_P;
    for (int n = 1; n < KEY_TABLE; n++) sched[n] = sched[n - 1] + RC5_Q;
    steps = 3 * ((KEY_TABLE > words) ? KEY_TABLE : words);
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    for (int n = 0; n < steps; n++) begin
      a = spin_left(sched[i] + a + b, 5'd3);
      sched[i] = a;
      amt = a + b;
      b = spin_left(mix[j] + a + b, amt[4:0]);
      mix[j] = b;
      i = (i + 1) % KEY_TABLE;
      j = (j + 1) % words;
    end
  endtask

  task automatic apply_block(input in_item_t w, output out_item_t res);
    bit [31:0] a;
    bit [31:0] b;
    a = w.block_a;
    b = w.block_b;
    case (w.operation)
      OP_ENCRYPT: begin
        a = a + sched[0];
        b = b + sched[1];
        for (int rnd = 1; rnd <= ROUND_COUNT; rnd++) begin
          a = spin_left(a ^ b, b[4:0]) + sched[2 * rnd];
          b = spin_left(b ^ a, a[4:0]) + sched[2 * rnd + 1];
        end
      end
      OP_DECRYPT: begin
        for (int rnd = ROUND_COUNT; rnd >= 1; rnd--) begin
          b = spin_right(b - sched[2 * rnd + 1], a[4:0]) ^ a;
          a = spin_right(a - sched[2 * rnd], b[4:0]) ^ b;
        end
        a = a - sched[0];
        b = b - sched[1];
      end
      OP_EXPAND: begin
        expand_schedule();
        a = '0;
        b = '0;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
    res.out_a = a;
    res.out_b = b;
  endtask

  // holds the word until accepted, then predicts its result
  task automatic offer_word(input in_item_t w, output out_item_t res);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_block(w, res);
    if (w.operation == OP_ENCRYPT) last_cipher = {res.out_a, res.out_b};
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input bit [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_KEY_WORDS_0_1: key_reg_copy[0] = value;
      CFG_KEY_WORDS_2_3: key_reg_copy[1] = value;
      CFG_KEY_WORDS_4_5: key_reg_copy[2] = value;
      CFG_KEY_WORDS_6_7: key_reg_copy[3] = value;
      CFG_KEY_WORD_COUNT: word_count_copy = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic bit [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  function automatic bit [63:0] pick_key();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic in_item_t pick_item();
    in_item_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    w.block_a = pick_word();
    w.block_b = pick_word();
    if (roll < 45) begin
      w.operation = OP_ENCRYPT;
    end else if (roll < 90) begin
      w.operation = OP_DECRYPT;
      // undo a recent encryption now and then
      if (roll < 60) {w.block_a, w.block_b} = last_cipher;
    end else if (roll < 96) begin
      w.operation = OP_EXPAND;
    end else begin
      w.operation = OP_UNUSED;
    end
    return w;
  endfunction

  // stimulus
  initial begin
    in_item_t  w;
    out_item_t res;
    out_item_t fixed;
    bit [63:0] keys [4];
    bit [3:0]  cnt;
    int        phase_words;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key (all zero, four words) first, so the table is written before use
    for (int n = 0; n < $size(opening_vectors); n++) begin
      w.operation = opening_vectors[n].op;
      w.block_a = opening_vectors[n].a;
      w.block_b = opening_vectors[n].b;
      offer_word(w, res);
      if (opening_vectors[n].fixed_result) begin
        fixed.out_a = opening_vectors[n].ea;
        fixed.out_b = opening_vectors[n].eb;
        blocks_due.push_back(fixed);
      end else begin
        blocks_due.push_back(res);
      end
    end
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int k = 0; k < 4; k++) keys[k] = pick_key();
      cnt = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(0, 15));
      case (phase)
        0: begin
          for (int k = 0; k < 4; k++) keys[k] = '1;
          cnt = 4'd8;
        end
        1: cnt = 4'd15;
        2: cnt = 4'd0;
        3: cnt = 4'd3;
        4: begin
          for (int k = 0; k < 4; k++) keys[k] = '0;
          cnt = 4'd4;
        end
        default: ;
      endcase
      write_reg(CFG_KEY_WORDS_0_1, keys[0]);
      write_reg(CFG_KEY_WORDS_2_3, keys[1]);
      write_reg(CFG_KEY_WORDS_4_5, keys[2]);
      write_reg(CFG_KEY_WORDS_6_7, keys[3]);
      write_reg(CFG_KEY_WORD_COUNT, {60'h0, cnt});
      cfg_write <= 1'b0;

      send_gaps = (phase % 4 != 2);
      recv_stalls = (phase % 3 != 1);
      // receiver stops for a long stretch while words keep coming
      if (phase == 5 || phase == 9) begin
        send_gaps = 1'b0;
        hold_off_req = 1'b1;
      end

      w.operation = OP_EXPAND;
      w.block_a = pick_word();
      w.block_b = pick_word();
      offer_word(w, res);
      blocks_due.push_back(res);
      phase_words = 1;
      while (phase_words < PHASE_WORDS) begin
        w = pick_item();
        offer_word(w, res);
        blocks_due.push_back(res);
        if (w.operation != OP_UNUSED) phase_words++;
      end
      settle();
    end

    repeat (ROUND_COUNT + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // output side back-pressure
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_stalls ? $urandom_range(0, 7) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (blocks_due.size() == 0) begin
        $error("output word with no result outstanding: %h", out_data);
        mismatch_count++;
      end else begin
        due_block = blocks_due.pop_front();
        if (out_data.out_a !== due_block.out_a) begin
          $error("out_a: expected %h, actual %h", due_block.out_a, out_data.out_a);
          mismatch_count++;
        end
        if (out_data.out_b !== due_block.out_b) begin
          $error("out_b: expected %h, actual %h", due_block.out_b, out_data.out_b);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
